// ===== rtl/core/mouse_packet_assembler_queue_macros.svh =====
// Assertion macros used by the mouse packet assembler queue.
`ifndef MOUSE_PACKET_ASSEMBLER_QUEUE_MACROS_SVH
`define MOUSE_PACKET_ASSEMBLER_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPAQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPAQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mpaq_pkg.sv =====
package mpaq_pkg;

  // Event queue geometry; the ring holds QUEUE_DEPTH-1 events.
  localparam int QUEUE_DEPTH = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  // Command queue between the front and back parts.
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam int BYTE_W  = 8;
  localparam int DELTA_W = 9;

  // Request codes.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  // Bit positions within the first packet byte.
  localparam int BIT_LEFT   = 0;
  localparam int BIT_RIGHT  = 1;
  localparam int BIT_MIDDLE = 2;
  localparam int BIT_SYNC   = 3;
  localparam int BIT_SIGN_X = 4;
  localparam int BIT_SIGN_Y = 5;
  localparam int BIT_OVF_X  = 6;
  localparam int BIT_OVF_Y  = 7;

  typedef struct packed {
    logic [DELTA_W-1:0] move_y;
    logic [DELTA_W-1:0] move_x;
    logic               middle;
    logic               right;
    logic               left;
  } event_t;

  typedef struct packed {
    logic   is_poll;
    event_t ev;
  } cmd_t;

  function automatic event_t assemble_event(input logic [BYTE_W-1:0] b0,
                                            input logic [BYTE_W-1:0] b1,
                                            input logic [BYTE_W-1:0] b2);
    event_t e;
    e.left   = b0[BIT_LEFT];
    e.right  = b0[BIT_RIGHT];
    e.middle = b0[BIT_MIDDLE];
    e.move_x = b0[BIT_OVF_X] ? '0 : {b0[BIT_SIGN_X], b1};
    e.move_y = b0[BIT_OVF_Y] ? '0 : {b0[BIT_SIGN_Y], b2};
    return e;
  endfunction

endpackage

// ===== rtl/core/mpaq_ifs.sv =====
interface mpaq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [mpaq_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface mpaq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               event_present;
  logic                               left_pressed;
  logic                               right_pressed;
  logic                               middle_pressed;
  logic signed [mpaq_pkg::DELTA_W-1:0] move_x;
  logic signed [mpaq_pkg::DELTA_W-1:0] move_y;

  modport source (output valid, output event_present, output left_pressed,
                  output right_pressed, output middle_pressed, output move_x,
                  output move_y, input ready);
  modport sink (input valid, input event_present, input left_pressed,
                input right_pressed, input middle_pressed, input move_x,
                input move_y, output ready);
endinterface

// ===== rtl/core/mpaq_cmd_fifo.sv =====
module mpaq_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  mpaq_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mpaq_pkg::cmd_t pop_cmd
);

  mpaq_pkg::cmd_t                     slots [mpaq_pkg::CMD_DEPTH];
  logic [mpaq_pkg::CMD_PTR_W-1:0]     wr_ptr;
  logic [mpaq_pkg::CMD_PTR_W-1:0]     rd_ptr;
  logic [mpaq_pkg::CMD_CNT_W-1:0]     count;
  logic                               do_push;
  logic                               do_pop;

  assign push_ready = (count != mpaq_pkg::CMD_CNT_W'(mpaq_pkg::CMD_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == mpaq_pkg::CMD_PTR_W'(mpaq_pkg::CMD_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == mpaq_pkg::CMD_PTR_W'(mpaq_pkg::CMD_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/mpaq_front.sv =====
module mpaq_front (
  input  logic           clk,
  input  logic           rst,
  mpaq_req_if.sink       req,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output mpaq_pkg::cmd_t cmd
);

  logic [1:0]                   byte_position;
  logic [1:0]                   byte_position_next;
  logic [mpaq_pkg::BYTE_W-1:0]  byte0;
  logic [mpaq_pkg::BYTE_W-1:0]  byte1;
  logic                         accept;
  logic                         is_poll;
  logic                         completes;

  // The front stalls only when the command queue is full.
  assign req.ready = cmd_ready;
  assign accept    = req.valid && cmd_ready;
  assign is_poll   = (req.req_type == mpaq_pkg::REQ_POLL);
  assign completes = !is_poll && (byte_position == 2'd2);

  assign cmd_valid   = req.valid && (is_poll || completes);
  assign cmd.is_poll = is_poll;
  assign cmd.ev      = mpaq_pkg::assemble_event(byte0, byte1, req.rx_byte);

  always_comb begin
    byte_position_next = byte_position;
    if (!is_poll) begin
      unique case (byte_position)
        2'd0: begin
          if (req.rx_byte[mpaq_pkg::BIT_SYNC]) begin
            byte_position_next = 2'd1;
          end
        end
        2'd1: byte_position_next = 2'd2;
        default: byte_position_next = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_poll) begin
      if (byte_position == 2'd0) begin
        byte0 <= req.rx_byte;
      end
      if (byte_position == 2'd1) begin
        byte1 <= req.rx_byte;
      end
    end
  end

endmodule

// ===== rtl/core/mpaq_back.sv =====
`include "mouse_packet_assembler_queue_macros.svh"

module mpaq_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  mpaq_pkg::cmd_t cmd,
  mpaq_rsp_if.source     rsp
);

  mpaq_pkg::event_t              store [mpaq_pkg::QUEUE_DEPTH];
  mpaq_pkg::event_t              rd_data;
  logic [mpaq_pkg::PTR_W-1:0]    wr_ptr;
  logic [mpaq_pkg::PTR_W-1:0]    rd_ptr;
  logic [mpaq_pkg::PTR_W-1:0]    wr_ptr_inc;
  logic [mpaq_pkg::PTR_W-1:0]    rd_ptr_inc;
  logic                          out_valid;
  logic                          out_present;
  logic                          take;
  logic                          take_push;
  logic                          take_poll;
  logic                          empty;
  logic                          full;
  logic                          push_ok;
  logic                          pop_ok;

  assign wr_ptr_inc = (wr_ptr == mpaq_pkg::PTR_W'(mpaq_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : wr_ptr + 1'b1;
  assign rd_ptr_inc = (rd_ptr == mpaq_pkg::PTR_W'(mpaq_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : rd_ptr + 1'b1;
  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr_inc == rd_ptr);

  // Pushes never wait; a poll waits only for room in the output register.
  assign cmd_ready = cmd.is_poll ? (!out_valid || rsp.ready) : 1'b1;
  assign take      = cmd_valid && cmd_ready;
  assign take_push = take && !cmd.is_poll;
  assign take_poll = take && cmd.is_poll;
  assign push_ok   = take_push && !full;
  assign pop_ok    = take_poll && !empty;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      store[wr_ptr] <= cmd.ev;
    end
    if (pop_ok) begin
      rd_data <= store[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      out_valid   <= 1'b0;
      out_present <= 1'b0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr_inc;
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr_inc;
      end
      if (take_poll) begin
        out_valid   <= 1'b1;
        out_present <= !empty;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // An empty poll reports zeros, so the stale read data is masked.
  assign rsp.valid          = out_valid;
  assign rsp.event_present  = out_present;
  assign rsp.left_pressed   = out_present && rd_data.left;
  assign rsp.right_pressed  = out_present && rd_data.right;
  assign rsp.middle_pressed = out_present && rd_data.middle;
  assign rsp.move_x         = out_present ? $signed(rd_data.move_x) : '0;
  assign rsp.move_y         = out_present ? $signed(rd_data.move_y) : '0;

  `MPAQ_ASSERT_NEXT(a_drop_when_full, push_ok == 1'b0 && take_push, $stable(wr_ptr), "event written into a full queue")
  `MPAQ_ASSERT_NEXT(a_empty_poll_zero, take_poll && empty, out_valid && !out_present, "empty poll did not report an absent event")
  `MPAQ_ASSERT_SAME(a_no_pop_empty, pop_ok, !empty && !full || !empty, "pop issued on an empty queue")
  `MPAQ_ASSERT_NEXT(a_pop_moves_ptr, pop_ok, rd_ptr != $past(rd_ptr), "read pointer did not advance on a pop")

endmodule

// ===== rtl/core/mouse_packet_assembler_queue.sv =====
// Polls pass through the command queue and then the output register, which holds the
// result valid until the receiver takes it. Throughput: one item per cycle, received
// byte or poll, while the command queue has room; set by the single-port event store
// in the back part, which serves one push or one pop each cycle.
// Reset: synchronous and active high; it clears the byte position, the queue
// pointers and the output valid. The event store is not cleared and needs no pass.
module mouse_packet_assembler_queue (
  input  logic       clk,
  input  logic       rst,
  mpaq_req_if.sink   req,
  mpaq_rsp_if.source rsp
);

  // The front part assembles three-byte packets from received bytes and turns
  // each completed packet into a push command and each poll into a poll
  // command. The commands pass through a short queue in arrival order, so the
  // back part sees pushes and polls exactly as the items arrived.
  logic           front_valid;
  logic           front_ready;
  mpaq_pkg::cmd_t front_cmd;

  logic           back_valid;
  logic           back_ready;
  mpaq_pkg::cmd_t back_cmd;

  mpaq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // The command queue lets the front keep taking items while a result waits
  // at the output, and lets the back keep storing events while the front is
  // idle.
  mpaq_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  // The back part owns the event ring. It drops an event when the ring is
  // full and answers every poll with exactly one result item.
  mpaq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .rsp       (rsp)
  );

endmodule

// ===== dv/tb_mouse_packet_assembler_queue.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the mouse packet assembler.
//
// A short table of hand-picked items runs first. It covers polls of an empty queue,
// bytes that lack the sync bit, the field extremes and both overflow bits. A long
// random run follows. It is mostly well-formed three-byte packets with random
// content. Polls, stray bytes and polls inside a packet are mixed in. Phases that
// are heavy on packets fill the event queue until events are dropped. Phases that
// are heavy on polls drain it and poll it empty. Every accepted item goes through a
// behavioral copy of the packet decoder and queue. Each poll leaves one expected
// result, and the results are checked in order as they are accepted.
module tb_mouse_packet_assembler_queue;

  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int DIRECTED_ROWS = 25;

  // One poll result as the block reports it.
  typedef struct packed {
    logic               present;
    logic               left;
    logic               right;
    logic               middle;
    logic signed [mpaq_pkg::DELTA_W-1:0] dx;
    logic signed [mpaq_pkg::DELTA_W-1:0] dy;
  } poll_reply_t;

  // One row of the directed table. When typed is set, want is the result that a
  // poll must return. Otherwise the decoder copy below supplies the result.
  typedef struct packed {
    logic                        kind;
    logic [mpaq_pkg::BYTE_W-1:0] data;
    logic                        typed;
    poll_reply_t                 want;
  } stim_row_t;

  localparam poll_reply_t NO_EVENT = '0;

  logic clk;
  logic rst;

  mpaq_req_if req_ch ();
  mpaq_rsp_if rsp_ch ();

  mouse_packet_assembler_queue DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Hand-picked opening sequence. The expected results are typed in where they are
  // obvious: empty polls, and packets built from all-zero, all-one or sign-only
  // bytes.
  stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    // Poll straight after reset: the queue is empty.
    '{mpaq_pkg::REQ_POLL, 8'h00, 1'b1, NO_EVENT},
    // No sync bit, so this byte is dropped.
    '{mpaq_pkg::REQ_BYTE, 8'h00, 1'b0, NO_EVENT},
    // All bits set except sync: also dropped.
    '{mpaq_pkg::REQ_BYTE, 8'hF7, 1'b0, NO_EVENT},
    // The byte field of a poll is a don't-care.
    '{mpaq_pkg::REQ_POLL, 8'hFF, 1'b1, NO_EVENT},
    // Minimal packet: sync bit only, zero motion.
    '{mpaq_pkg::REQ_BYTE, 8'h08, 1'b0, NO_EVENT},
    '{mpaq_pkg::REQ_BYTE, 8'h00, 1'b0, NO_EVENT},
    '{mpaq_pkg::REQ_BYTE, 8'h00, 1'b0, NO_EVENT},
    // Every button pressed, both overflow bits set.
    '{mpaq_pkg::REQ_BYTE, 8'hFF, 1'b0, NO_EVENT},
    '{mpaq_pkg::REQ_BYTE, 8'hFF, 1'b0, NO_EVENT},
    '{mpaq_pkg::REQ_BYTE, 8'hFF, 1'b0, NO_EVENT},
    // Every button pressed, both deltas at -1.
    '{mpaq_pkg::REQ_BYTE, 8'h3F, 1'b0, NO_EVENT},
    '{mpaq_pkg::REQ_BYTE, 8'hFF, 1'b0, NO_EVENT},
    '{mpaq_pkg::REQ_BYTE, 8'hFF, 1'b0, NO_EVENT},
    // X at its most negative, Y at +128.
    '{mpaq_pkg::REQ_BYTE, 8'h18, 1'b0, NO_EVENT},
    '{mpaq_pkg::REQ_BYTE, 8'h00, 1'b0, NO_EVENT},
    '{mpaq_pkg::REQ_BYTE, 8'h80, 1'b0, NO_EVENT},
    '{mpaq_pkg::REQ_POLL, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 9'h000, 9'h000}},
    '{mpaq_pkg::REQ_POLL, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b1, 9'h000, 9'h000}},
    '{mpaq_pkg::REQ_POLL, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b1, 9'h1FF, 9'h1FF}},
    '{mpaq_pkg::REQ_POLL, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 9'h100, 9'h080}},
    // The queue has drained again.
    '{mpaq_pkg::REQ_POLL, 8'h00, 1'b1, NO_EVENT},
    // Left button with a negative Y.
    '{mpaq_pkg::REQ_BYTE, 8'h29, 1'b0, NO_EVENT},
    '{mpaq_pkg::REQ_BYTE, 8'h55, 1'b0, NO_EVENT},
    '{mpaq_pkg::REQ_BYTE, 8'hAA, 1'b0, NO_EVENT},
    '{mpaq_pkg::REQ_POLL, 8'h00, 1'b0, NO_EVENT}
  };

  // State of the decoder copy: the packet being assembled and the pending events.
  logic [1:0]                  bytes_held;
  logic [mpaq_pkg::BYTE_W-1:0] first_byte;
  logic [mpaq_pkg::BYTE_W-1:0] second_byte;
  mpaq_pkg::event_t            queued_events[$];

  // Poll results that the block still owes, oldest first.
  poll_reply_t replies_due[$];
  poll_reply_t oldest_reply;

  int  errors;
  int  quiet_cycles;
  bit  bursts_on;       // Random idle bursts on both channels are allowed.
  bit  hold_request;    // Asks the receiver for one long stall.
  bit  hold_issued;
  int  counted;         // Input items accepted so far.
  int  poll_pct;
  int  roll;
  bit  fill_heavy;
  logic [mpaq_pkg::BYTE_W-1:0] head_byte;

  // Apply one accepted item to the decoder copy. Returns 1 when the item is a poll,
  // and then reply holds the result that the poll must produce.
  function automatic bit step_mouse(input logic kind,
                                    input logic [mpaq_pkg::BYTE_W-1:0] data,
                                    output poll_reply_t reply);
    mpaq_pkg::event_t mouse_ev;
    reply = NO_EVENT;
    if (kind == mpaq_pkg::REQ_BYTE) begin
      case (bytes_held)
        2'd0: begin
          // A packet may only open on a byte that has the sync bit set.
          if (data[mpaq_pkg::BIT_SYNC]) begin
            first_byte = data;
            bytes_held = 2'd1;
          end
        end
        2'd1: begin
          second_byte = data;
          bytes_held = 2'd2;
        end
        default: begin
          // The third byte completes the packet. Each delta takes its ninth bit
          // from the sign bit in the first byte, and is zero on overflow.
          mouse_ev.left   = first_byte[mpaq_pkg::BIT_LEFT];
          mouse_ev.right  = first_byte[mpaq_pkg::BIT_RIGHT];
          mouse_ev.middle = first_byte[mpaq_pkg::BIT_MIDDLE];
          mouse_ev.move_x = {first_byte[mpaq_pkg::BIT_SIGN_X], second_byte};
          mouse_ev.move_y = {first_byte[mpaq_pkg::BIT_SIGN_Y], data};
          if (first_byte[mpaq_pkg::BIT_OVF_X]) mouse_ev.move_x = '0;
          if (first_byte[mpaq_pkg::BIT_OVF_Y]) mouse_ev.move_y = '0;
          // The ring keeps one slot free, so it holds one event fewer than its depth.
          // An event that arrives when the ring is full is lost.
          if (queued_events.size() < mpaq_pkg::QUEUE_DEPTH - 1) begin
            queued_events.push_back(mouse_ev);
          end
          bytes_held = 2'd0;
        end
      endcase
      return 1'b0;
    end
    if (queued_events.size() != 0) begin
      mouse_ev = queued_events.pop_front();
      reply.present = 1'b1;
      reply.left    = mouse_ev.left;
      reply.right   = mouse_ev.right;
      reply.middle  = mouse_ev.middle;
      reply.dx      = mouse_ev.move_x;
      reply.dy      = mouse_ev.move_y;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic signed [9:0] want,
                                      input logic signed [9:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Offer one item to the block and hold it until it is accepted. An idle gap may
  // come first. When the item is accepted, it goes through the decoder copy.
  task automatic offer(input logic kind, input logic [mpaq_pkg::BYTE_W-1:0] data,
                       input bit typed, input poll_reply_t want);
    poll_reply_t reply;
    if (bursts_on && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.rx_byte  <= data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    counted++;
    if (step_mouse(kind, data, reply)) replies_due.push_back(typed ? want : reply);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver is ready by default. While bursts are on, it drops ready at random.
  // One long hold, when requested, backs the block up until it refuses further items.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      if (hold_request) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (bursts_on && $urandom_range(0, 9) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Result checker: every accepted result must match the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (replies_due.size() == 0) begin
        $error("poll result accepted with no poll outstanding");
        errors++;
      end else begin
        oldest_reply = replies_due.pop_front();
        check_field("event_present", 10'(oldest_reply.present),
                    10'(rsp_ch.event_present));
        check_field("left_pressed", 10'(oldest_reply.left), 10'(rsp_ch.left_pressed));
        check_field("right_pressed", 10'(oldest_reply.right), 10'(rsp_ch.right_pressed));
        check_field("middle_pressed", 10'(oldest_reply.middle),
                    10'(rsp_ch.middle_pressed));
        check_field("move_x", 10'(oldest_reply.dx), 10'(rsp_ch.move_x));
        check_field("move_y", 10'(oldest_reply.dy), 10'(rsp_ch.move_y));
      end
    end
  end

  // Watchdog: too many cycles in a row with no handshake on either side means
  // the block has hung.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    errors       = 0;
    quiet_cycles = 0;
    bursts_on    = 1'b1;
    hold_request = 1'b0;
    hold_issued  = 1'b0;
    counted      = 0;
    bytes_held   = 2'd0;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= mpaq_pkg::REQ_BYTE;
    req_ch.rx_byte  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].typed,
            directed_rows[i].want);
    end

    // Random part. Fill phases offer few polls, so the ring fills and events are
    // lost. Drain phases poll often, so many polls find the ring empty. Idle bursts
    // come and go in stretches and stop for the last part of the run. The one long
    // receiver hold falls in a fill phase.
    while (counted < RANDOM_ITEMS) begin
      fill_heavy = ((counted / 160) % 2) == 0;
      bursts_on  = (counted < RANDOM_ITEMS - 200) && ((counted / 100) % 4 != 3);
      if (!hold_issued && counted >= 400 && fill_heavy) begin
        hold_request = 1'b1;
        hold_issued  = 1'b1;
      end
      poll_pct = fill_heavy ? 15 : 60;
      roll = $urandom_range(0, 99);
      if (roll < poll_pct) begin
        offer(mpaq_pkg::REQ_POLL, 8'($urandom_range(0, 255)), 1'b0, NO_EVENT);
      end else if (roll < poll_pct + 8) begin
        // A stray byte. It is dropped when it lacks the sync bit. Otherwise it
        // opens a packet that is out of step with the bytes that follow.
        offer(mpaq_pkg::REQ_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_EVENT);
      end else begin
        // A well-formed packet. Most have both overflow bits clear, so that the
        // deltas carry the data. Now and then a poll falls inside the packet.
        head_byte = 8'($urandom_range(0, 255));
        head_byte[mpaq_pkg::BIT_SYNC] = 1'b1;
        if ($urandom_range(0, 3) != 0) begin
          head_byte[mpaq_pkg::BIT_OVF_X] = 1'b0;
          head_byte[mpaq_pkg::BIT_OVF_Y] = 1'b0;
        end
        offer(mpaq_pkg::REQ_BYTE, head_byte, 1'b0, NO_EVENT);
        if ($urandom_range(0, 9) == 0) begin
          offer(mpaq_pkg::REQ_POLL, 8'($urandom_range(0, 255)), 1'b0, NO_EVENT);
        end
        offer(mpaq_pkg::REQ_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_EVENT);
        if ($urandom_range(0, 9) == 0) begin
          offer(mpaq_pkg::REQ_POLL, 8'($urandom_range(0, 255)), 1'b0, NO_EVENT);
        end
        offer(mpaq_pkg::REQ_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_EVENT);
      end
    end
    req_ch.valid <= 1'b0;

    // Wait for every outstanding result, then keep the clock running so that a stray
    // extra result would still be caught.
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== mouse_packet_assembler_queue.f =====
+incdir+rtl/core
rtl/core/mpaq_pkg.sv
rtl/core/mpaq_ifs.sv
rtl/core/mpaq_cmd_fifo.sv
rtl/core/mpaq_front.sv
rtl/core/mpaq_back.sv
rtl/core/mouse_packet_assembler_queue.sv
dv/tb_mouse_packet_assembler_queue.sv
